>>> hdl/g7rtp_pkg.sv
// Shared constants, queue entry type and G.711 encoding functions for the RTP packetizer.
package g7rtp_pkg;

  localparam int unsigned MAX_PAYLOAD = 1500;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned HDR_BYTES   = 12;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = 2;

  localparam logic       OP_SAMPLE    = 1'b0;
  localparam logic       OP_DISCONT   = 1'b1;
  localparam logic [6:0] PT_ALAW      = 7'd8;
  localparam logic [7:0] RTP_VER_BYTE = 8'h80;

  localparam logic       CFG_PAYLOAD_TYPE = 1'b0;
  localparam logic       CFG_SOURCE_ID    = 1'b1;

  typedef struct packed {
    logic        hdr;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  code;
    logic        last;
  } entry_t;

  function automatic logic [7:0] enc_ulaw(input logic signed [15:0] s);
    logic [15:0] mag;
    logic [2:0]  ex;
    logic [3:0]  mant;
    mag = s[15] ? 16'(-s) : 16'(s);
    if (mag > 16'd32635) begin
      mag = 16'd32635;
    end
    mag = mag + 16'h0084;
    ex = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (mag[7 + i]) begin
        ex = 3'(i);
      end
    end
    mant = 4'(mag >> ({1'b0, ex} + 4'd3));
    return ~{s[15], ex, mant};
  endfunction

  function automatic logic [7:0] enc_alaw(input logic signed [15:0] s);
    logic [11:0] mag;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic [7:0]  flip;
    if (!s[15]) begin
      flip = 8'hD5;
      mag  = s[14:3];
    end else begin
      flip = 8'h55;
      mag  = ~s[14:3];
    end
    seg = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (mag > 12'((32 << i) - 1)) begin
        seg = 3'(i + 1);
      end
    end
    if (seg < 3'd2) begin
      mant = mag[4:1];
    end else begin
      mant = 4'(mag >> seg);
    end
    return {1'b0, seg, mant} ^ flip;
  endfunction

endpackage

>>> hdl/g7rtp_if.sv
// Valid/ready channel interfaces for the sample input and the packet byte output.
interface g7rtp_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] sample;
  logic               end_of_frame;

  modport source (output valid, operation, sample, end_of_frame, input ready);
  modport sink   (input valid, operation, sample, end_of_frame, output ready);
endinterface

interface g7rtp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, out_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, first_byte, last_byte, output ready);
endinterface

>>> hdl/g7rtp_front.sv
// Front end: accepts items, tracks packet state, encodes samples and queues byte jobs.
module g7rtp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [6:0]           payload_type,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic signed [15:0]   in_sample,
  input  logic                 in_end_of_frame,
  input  logic                 q_full,
  output logic                 q_push,
  output g7rtp_pkg::entry_t    q_entry
);

  logic                           in_packet_r, in_packet_nxt;
  logic                           marker_r, marker_nxt;
  logic [g7rtp_pkg::CNT_W-1:0]    pcount_r, pcount_nxt;
  logic [15:0]                    seq_r, seq_nxt;
  logic [31:0]                    ts_r, ts_nxt;
  logic                           accept;
  logic                           is_sample;
  logic                           hdr;
  logic [g7rtp_pkg::CNT_W-1:0]    cnt;
  logic [g7rtp_pkg::CNT_W-1:0]    cnt_new;
  logic                           keep;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_sample = (in_operation == g7rtp_pkg::OP_SAMPLE);
  assign hdr       = !in_packet_r;
  assign cnt       = hdr ? '0 : pcount_r;
  assign keep      = (cnt < g7rtp_pkg::CNT_W'(g7rtp_pkg::MAX_PAYLOAD));
  assign cnt_new   = keep ? cnt + 1'b1 : cnt;

  assign q_push         = accept && is_sample && keep;
  assign q_entry.hdr    = hdr;
  assign q_entry.marker = marker_r;
  assign q_entry.seq    = seq_r;
  assign q_entry.ts     = ts_r;
  assign q_entry.code   = (payload_type == g7rtp_pkg::PT_ALAW) ?
                          g7rtp_pkg::enc_alaw(in_sample) : g7rtp_pkg::enc_ulaw(in_sample);
  assign q_entry.last   = in_end_of_frame ||
                          (cnt_new >= g7rtp_pkg::CNT_W'(g7rtp_pkg::MAX_PAYLOAD));

  always_comb begin
    in_packet_nxt = in_packet_r;
    marker_nxt    = marker_r;
    pcount_nxt    = pcount_r;
    seq_nxt       = seq_r;
    ts_nxt        = ts_r;
    if (accept) begin
      if (!is_sample) begin
        marker_nxt = 1'b1;
      end else begin
        if (hdr) begin
          marker_nxt = 1'b0;
        end
        in_packet_nxt = 1'b1;
        pcount_nxt    = cnt_new;
        if (in_end_of_frame) begin
          seq_nxt       = seq_r + 16'd1;
          ts_nxt        = ts_r + {{(32 - g7rtp_pkg::CNT_W){1'b0}}, cnt_new};
          pcount_nxt    = '0;
          in_packet_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      marker_r    <= 1'b1;
      pcount_r    <= '0;
      seq_r       <= '0;
      ts_r        <= '0;
    end else begin
      in_packet_r <= in_packet_nxt;
      marker_r    <= marker_nxt;
      pcount_r    <= pcount_nxt;
      seq_r       <= seq_nxt;
      ts_r        <= ts_nxt;
    end
  end

endmodule

>>> hdl/g7rtp_fifo.sv
// Short register queue of byte jobs between the front end and the byte emitter.
module g7rtp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  g7rtp_pkg::entry_t push_entry,
  input  logic              pop,
  output g7rtp_pkg::entry_t head,
  output logic              full,
  output logic              empty
);

  g7rtp_pkg::entry_t                store_r [g7rtp_pkg::FIFO_DEPTH];
  logic [g7rtp_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [g7rtp_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [g7rtp_pkg::FIFO_AW:0]      count_r, count_nxt;

  assign full  = (count_r == (g7rtp_pkg::FIFO_AW + 1)'(g7rtp_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("Job queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("Job queue read while empty.");
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[g7rtp_pkg::FIFO_AW-1:0] == (wr_ptr_r - rd_ptr_r)))
    else $error("Job queue count disagrees with its pointers.");

endmodule

>>> hdl/g7rtp_back.sv
// Back end: turns queued jobs into header and payload bytes through an output register.
module g7rtp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        payload_type,
  input  logic [31:0]       source_id,
  input  g7rtp_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_first_byte,
  output logic              out_last_byte
);

  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  byte_r;
  logic                        first_r;
  logic                        last_r;
  logic [g7rtp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                        load;
  logic                        is_pay;
  logic [7:0]                  hdr_byte;
  logic [7:0]                  sel_byte;

  assign load   = !empty && (!out_valid_r || out_ready);
  assign is_pay = !head.hdr || (idx_r == g7rtp_pkg::IDX_W'(g7rtp_pkg::HDR_BYTES));
  assign pop    = load && is_pay;

  always_comb begin
    unique case (idx_r)
      4'd0:    hdr_byte = g7rtp_pkg::RTP_VER_BYTE;
      4'd1:    hdr_byte = {head.marker, payload_type};
      4'd2:    hdr_byte = head.seq[15:8];
      4'd3:    hdr_byte = head.seq[7:0];
      4'd4:    hdr_byte = head.ts[31:24];
      4'd5:    hdr_byte = head.ts[23:16];
      4'd6:    hdr_byte = head.ts[15:8];
      4'd7:    hdr_byte = head.ts[7:0];
      4'd8:    hdr_byte = source_id[31:24];
      4'd9:    hdr_byte = source_id[23:16];
      4'd10:   hdr_byte = source_id[15:8];
      4'd11:   hdr_byte = source_id[7:0];
      default: hdr_byte = head.code;
    endcase
  end

  assign sel_byte = is_pay ? head.code : hdr_byte;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = pop ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= sel_byte;
      first_r <= head.hdr && (idx_r == '0);
      last_r  <= is_pay && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_first_byte = first_r;
  assign out_last_byte  = last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= g7rtp_pkg::IDX_W'(g7rtp_pkg::HDR_BYTES))
    else $error("Header byte index out of range.");
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(first_r && last_r))
    else $error("One byte flagged both first and last.");
  a_first_is_version: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && first_r) |-> (byte_r == g7rtp_pkg::RTP_VER_BYTE))
    else $error("First byte of a packet is not the version byte.");

endmodule

>>> hdl/g711_rtp_packetizer.sv
// Top level of the G.711 RTP packetizer: configuration registers, front end, job queue, back end.
//
//   Channel  Direction  Handshake        Payload
//   in_ch    sink       valid/ready      operation, sample, end_of_frame
//   out_ch   source     valid/ready      out_byte, first_byte, last_byte
//   cfg_*    input      write enable     cfg_index, cfg_data
//
// A sample item is taken by the front end while the job queue is not full and yields one payload byte,
// or thirteen bytes when it opens a packet and the header is sent.
// The byte emitter sets the rate; a four-entry job queue lets input run on meanwhile.
// Discontinuity items and dropped samples yield no byte.
// Reset is synchronous; there is no clearing pass.
module g711_rtp_packetizer (
  input  logic              clk,
  input  logic              rst_n,
  g7rtp_in_if.sink          in_ch,
  g7rtp_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [6:0]        payload_type_r;
  logic [31:0]       source_id_r;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  g7rtp_pkg::entry_t q_in;
  g7rtp_pkg::entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_type_r <= '0;
      source_id_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        g7rtp_pkg::CFG_PAYLOAD_TYPE: payload_type_r <= cfg_data[6:0];
        g7rtp_pkg::CFG_SOURCE_ID:    source_id_r    <= cfg_data;
        default:                     source_id_r    <= source_id_r;
      endcase
    end
  end

  g7rtp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .payload_type    (payload_type_r),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_operation    (in_ch.operation),
    .in_sample       (in_ch.sample),
    .in_end_of_frame (in_ch.end_of_frame),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_in)
  );

  g7rtp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  g7rtp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .payload_type   (payload_type_r),
    .source_id      (source_id_r),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_first_byte (out_ch.first_byte),
    .out_last_byte  (out_ch.last_byte)
  );

endmodule
